// ----- hw/rtl/wsp_pkg.sv -----
// Shared types for the WAV stream PCM decoder.
// Request structs for both channels and the result kind codes.
// No dependencies.
package wsp_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
    logic       final_byte;
  } in_req_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] pcm_sample;
    logic               last_sample;
    logic [15:0]        format_tag;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic [31:0]        bytes_per_second;
    logic [15:0]        sample_bits;
  } out_req_t;

endpackage

// ----- hw/rtl/wsp_in_reg.sv -----
// Input register of the WAV stream PCM decoder.
// Holds one byte request until the parser takes it. Uses wsp_pkg.
module wsp_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  wsp_pkg::in_req_t in_req_i,
  input  logic             take_i,
  output logic             item_valid_o,
  output wsp_pkg::in_req_t item_o
);

  logic             valid_q, valid_d;
  wsp_pkg::in_req_t item_q;
  logic             accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_req_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hw/rtl/wsp_parser.sv -----
// Parser state and single-pass update logic of the WAV stream PCM decoder.
// Walks RIFF chunks, captures fmt fields and converts data bytes. Uses wsp_pkg.
module wsp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  wsp_pkg::in_req_t  item_i,
  output logic              has_o,
  output wsp_pkg::out_req_t res_o
);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_HEAD = 3'd1;
  localparam logic [2:0] PH_BODY = 3'd2;
  localparam logic [2:0] PH_PAD  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;

  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  typedef struct packed {
    logic [2:0]  phase;
    logic [31:0] pos;
    logic [31:0] tag;
    logic [31:0] len;
    logic        saw;
    logic        cap;
    logic [15:0] fmt_format;
    logic [15:0] fmt_chans;
    logic [31:0] fmt_rate;
    logic [31:0] fmt_brate;
    logic [15:0] fmt_bits;
    logic [7:0]  prev;
    logic [1:0]  bis;
    logic [31:0] left;
  } st_t;

  function automatic logic [7:0] riff_char(input logic [3:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (idx)
      4'd0:    c = 8'h52;
      4'd1:    c = 8'h49;
      4'd2:    c = 8'h46;
      4'd3:    c = 8'h46;
      4'd8:    c = 8'h57;
      4'd9:    c = 8'h41;
      4'd10:   c = 8'h56;
      4'd11:   c = 8'h45;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  st_t               st_q, st_d, cur;
  wsp_pkg::out_req_t res;
  logic              has;
  logic              chk_fin;
  logic              smp_done;
  logic              last;
  logic [2:0]        sz;
  logic [7:0]        b;
  logic              fin;
  logic [31:0]       left_n;
  logic [31:0]       pos_n;
  logic [31:0]       len_n;
  logic [31:0]       tag_n;

  assign b   = item_i.in_byte;
  assign fin = item_i.final_byte;
  assign cur = item_i.first_byte ? st_t'('0) : st_q;

  always_comb begin
    case (cur.fmt_bits)
      16'd8:   sz = 3'd1;
      16'd16:  sz = 3'd2;
      16'd24:  sz = 3'd3;
      16'd32:  sz = 3'd4;
      default: sz = 3'd0;
    endcase
  end

  always_comb begin
    st_d     = cur;
    res      = '0;
    has      = 1'b0;
    chk_fin  = 1'b1;
    smp_done = 1'b0;
    last     = 1'b0;
    left_n   = cur.left - 32'd1;
    pos_n    = cur.pos + 32'd1;
    len_n    = cur.len - 32'd1;
    tag_n    = {cur.tag[23:0], b};
    unique case (cur.phase)
      PH_DONE: begin
        chk_fin = 1'b0;
      end
      PH_DATA: begin
        chk_fin = 1'b0;
        if (cur.left == 32'd0) begin
          res.kind   = wsp_pkg::KIND_END;
          has        = 1'b1;
          st_d.phase = PH_DONE;
        end else begin
          st_d.left = left_n;
          if (sz != 3'd0) begin
            st_d.prev = b;
            if (({1'b0, cur.bis} + 3'd1) >= sz) begin
              last            = (left_n < {29'd0, sz}) || fin;
              smp_done        = 1'b1;
              st_d.bis        = 2'd0;
              res.kind        = wsp_pkg::KIND_SAMPLE;
              res.pcm_sample  = (sz == 3'd1) ? {b ^ 8'h80, 8'h00} : {b, cur.prev};
              res.last_sample = last;
              has             = 1'b1;
              if (last) begin
                st_d.phase = PH_DONE;
              end
            end else begin
              st_d.bis = cur.bis + 2'd1;
            end
          end
          if (!smp_done && ((left_n == 32'd0) || fin)) begin
            res.kind   = wsp_pkg::KIND_END;
            has        = 1'b1;
            st_d.phase = PH_DONE;
          end
        end
      end
      PH_RIFF: begin
        if ((cur.pos[3:2] != 2'b01) && (b != riff_char(cur.pos[3:0]))) begin
          chk_fin    = 1'b0;
          res.kind   = wsp_pkg::KIND_ERROR;
          has        = 1'b1;
          st_d.phase = PH_DONE;
        end else if (cur.pos[3:0] == 4'd11) begin
          st_d.phase = PH_HEAD;
          st_d.pos   = 32'd0;
        end else begin
          st_d.pos = pos_n;
        end
      end
      PH_HEAD: begin
        st_d.pos = pos_n;
        if (!cur.pos[2]) begin
          st_d.tag = tag_n;
        end else begin
          case (cur.pos[1:0])
            2'd0:    st_d.len[7:0]   = b;
            2'd1:    st_d.len[15:8]  = b;
            2'd2:    st_d.len[23:16] = b;
            default: st_d.len[31:24] = b;
          endcase
        end
        if (cur.pos[2:0] == 3'd7) begin
          st_d.pos = 32'd0;
          if (st_d.tag == TAG_DATA) begin
            chk_fin = 1'b0;
            has     = 1'b1;
            if (!cur.saw || (cur.fmt_chans == 16'd0) || (cur.fmt_bits == 16'd0)) begin
              res.kind   = wsp_pkg::KIND_ERROR;
              st_d.phase = PH_DONE;
            end else begin
              res.kind             = wsp_pkg::KIND_HEADER;
              res.format_tag       = cur.fmt_format;
              res.channel_count    = cur.fmt_chans;
              res.rate_hz          = cur.fmt_rate;
              res.bytes_per_second = cur.fmt_brate;
              res.sample_bits      = cur.fmt_bits;
              st_d.left            = st_d.len;
              st_d.bis             = 2'd0;
              st_d.prev            = 8'h00;
              st_d.phase           = fin ? PH_DONE : PH_DATA;
            end
          end else begin
            st_d.cap   = (st_d.tag == TAG_FMT) && (st_d.len >= FMT_MIN);
            st_d.saw   = cur.saw || st_d.cap;
            st_d.phase = (st_d.len == 32'd0) ? PH_HEAD : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (cur.cap && (cur.pos[31:4] == 28'd0)) begin
          case (cur.pos[3:0])
            4'd0:    st_d.fmt_format[7:0]  = b;
            4'd1:    st_d.fmt_format[15:8] = b;
            4'd2:    st_d.fmt_chans[7:0]   = b;
            4'd3:    st_d.fmt_chans[15:8]  = b;
            4'd4:    st_d.fmt_rate[7:0]    = b;
            4'd5:    st_d.fmt_rate[15:8]   = b;
            4'd6:    st_d.fmt_rate[23:16]  = b;
            4'd7:    st_d.fmt_rate[31:24]  = b;
            4'd8:    st_d.fmt_brate[7:0]   = b;
            4'd9:    st_d.fmt_brate[15:8]  = b;
            4'd10:   st_d.fmt_brate[23:16] = b;
            4'd11:   st_d.fmt_brate[31:24] = b;
            4'd14:   st_d.fmt_bits[7:0]    = b;
            4'd15:   st_d.fmt_bits[15:8]   = b;
            default: st_d.fmt_bits         = cur.fmt_bits;
          endcase
        end
        st_d.pos = pos_n;
        st_d.len = len_n;
        if (len_n == 32'd0) begin
          st_d.phase = pos_n[0] ? PH_PAD : PH_HEAD;
          st_d.pos   = 32'd0;
        end
      end
      default: begin
        st_d.phase = PH_HEAD;
        st_d.pos   = 32'd0;
      end
    endcase
    if (chk_fin && fin) begin
      res.kind   = wsp_pkg::KIND_ERROR;
      has        = 1'b1;
      st_d.phase = PH_DONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (en_i) begin
      st_q <= st_d;
    end
  end

  assign has_o = has;
  assign res_o = res;

endmodule

// ----- hw/rtl/wsp_out_reg.sv -----
// Result register of the WAV stream PCM decoder.
// Holds one result request until the consumer takes it. Uses wsp_pkg.
module wsp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              has_i,
  input  wsp_pkg::out_req_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsp_pkg::out_req_t out_req_o
);

  logic              valid_q, valid_d;
  wsp_pkg::out_req_t res_q;
  logic              fill;

  assign ready_o = !valid_q || !out_stall_i;
  assign fill    = ready_o && load_i && has_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = res_q;

endmodule

// ----- hw/rtl/wav_stream_pcm_decoder.sv -----
// Byte-serial RIFF/WAVE PCM decoder: input register, parser, result register.
// Instantiates wsp_in_reg, wsp_parser and wsp_out_reg. Uses wsp_pkg.
//
// Feed the file one byte per request, first_byte marking byte 0 and final_byte
// the last. The block sustains one byte per clock while no result is stalled:
// each byte is handled combinationally by the parser between the input register
// and the result register, which registers any result that the byte gives.
// While a result is stalled the parser holds, even for bytes that give no
// result, and the input register takes at most one more byte. A header result
// marks the data chunk, then signed 16-bit samples follow, last_sample or an
// end result flagging the end.
module wav_stream_pcm_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsp_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsp_pkg::out_req_t out_req_o
);

  logic              ready;
  logic              item_valid;
  logic              advance;
  logic              has;
  wsp_pkg::in_req_t  item;
  wsp_pkg::out_req_t res;

  assign advance = item_valid && ready;

  wsp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_req_i     (in_req_i),
    .take_i       (ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  wsp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item),
    .has_o  (has),
    .res_o  (res)
  );

  wsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .has_i       (has),
    .res_i       (res),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
